/* src/vtc_pkg.sv */
// ----------------------------------------------------------------------------
// vtc_pkg: shared types and constants for the version triple comparator
// Beat layouts, parser phase codes and the character constants that the
// parser, the checker and the testbench use.
// ----------------------------------------------------------------------------
`default_nettype none

package vtc_pkg;

  localparam int unsigned CompW          = 30;
  localparam int unsigned NumCompDefault = 3;
  localparam int unsigned OutComps       = 3;

  localparam logic [CompW-1:0] CompLimit = CompW'(99999999);
  localparam logic [7:0]       ChZero    = 8'h30;
  localparam logic [7:0]       ChNine    = 8'h39;
  localparam logic [7:0]       ChDot     = 8'h2E;

  typedef enum logic [1:0] {
    PhSeek = 2'd0,
    PhComp = 2'd1,
    PhDone = 2'd2
  } phase_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] ch;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic             newer;
    logic [CompW-1:0] cand_major;
    logic [CompW-1:0] cand_minor;
    logic [CompW-1:0] cand_patch;
    logic [CompW-1:0] inst_major;
    logic [CompW-1:0] inst_minor;
    logic [CompW-1:0] inst_patch;
  } out_beat_t;

  typedef struct packed {
    logic     step;
    in_beat_t beat;
  } parse_ctl_t;

endpackage

`default_nettype wire

/* src/version_triple_compare.sv */
// ----------------------------------------------------------------------------
// version_triple_compare: streaming compare of two dotted version strings
// Characters come in one beat at a time on the input channel: first the
// candidate string, then the installed string, each closed by a beat with
// last set. The mode bit of the closing beat says which string it was. A
// candidate string is parsed and held; the closing beat of an installed
// string produces one result beat with both triples and the newer flag.
// Every other input beat produces nothing.
// Throughput: one character beat per cycle, sustained. The input register
// takes a new beat every cycle while the result register is free or drains.
// A closing installed beat passes the input register, then the result
// register, where the result beat is valid; while the result register
// is not free, that beat waits in the input register.
// The parser and the multiply by ten sit between the input register and the
// result register; the triple compare works from the result register.
// Reset clears the parser, the held candidate (to zeros) and both valid
// flags. When the receiver stalls, the result beat holds; character beats
// keep flowing until a second result would be needed, then the input
// register holds that closing beat and in_ready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module version_triple_compare #(
  parameter int unsigned NUM_COMPONENTS = vtc_pkg::NumCompDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire vtc_pkg::in_beat_t  in_beat_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output vtc_pkg::out_beat_t      out_beat_o
);
  import vtc_pkg::*;

  // input register
  logic     s1_valid_q, s1_valid_d;
  in_beat_t s1_beat_q;
  logic     s1_emit;
  logic     s1_adv;
  logic     in_fire;

  // result register
  logic                                  out_valid_q, out_valid_d;
  logic                                  out_free;
  logic [NUM_COMPONENTS-1:0][CompW-1:0]  res_cand_q;
  logic [NUM_COMPONENTS-1:0][CompW-1:0]  res_inst_q;
  logic [NUM_COMPONENTS-1:0][CompW-1:0]  held_q;
  logic [NUM_COMPONENTS-1:0][CompW-1:0]  fin_triple;
  logic [OutComps-1:0][CompW-1:0]        cand_pad;
  logic [OutComps-1:0][CompW-1:0]        inst_pad;
  logic                                  greater;

  parse_ctl_t parse_ctl;

  // Only a closing installed beat needs the result register; all other
  // beats advance unconditionally.
  assign s1_emit    = s1_beat_q.last && s1_beat_q.mode;
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_emit || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // payload only; load on accept
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_beat_q <= in_beat_i;
    end
  end

  assign parse_ctl.step = s1_adv;
  assign parse_ctl.beat = s1_beat_q;

  vtc_parser #(
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (parse_ctl),
    .fin_triple_o (fin_triple)
  );

  // Hold the last finished candidate; it survives comparisons.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (s1_adv && s1_beat_q.last && !s1_beat_q.mode) begin
      held_q <= fin_triple;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_adv && s1_emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit) begin
      res_cand_q <= held_q;
      res_inst_q <= fin_triple;
    end
  end

  vtc_compare #(
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_compare (
    .cand_i    (res_cand_q),
    .inst_i    (res_inst_q),
    .greater_o (greater)
  );

  // Pad to three output fields; a fourth component is compared, not shown.
  always_comb begin
    cand_pad = '0;
    inst_pad = '0;
    for (int k = 0; k < OutComps; k++) begin
      if (k < NUM_COMPONENTS) begin
        cand_pad[k] = res_cand_q[k];
        inst_pad[k] = res_inst_q[k];
      end
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_beat_o.newer      = greater;
  assign out_beat_o.cand_major = cand_pad[0];
  assign out_beat_o.cand_minor = cand_pad[1];
  assign out_beat_o.cand_patch = cand_pad[2];
  assign out_beat_o.inst_major = inst_pad[0];
  assign out_beat_o.inst_minor = inst_pad[1];
  assign out_beat_o.inst_patch = inst_pad[2];

`ifndef SYNTH
  // an empty input register always takes a beat
  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input register empty but not ready");

  // a beat that yields no result never stalls
  a_no_result_flows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_emit) |-> s1_adv)
    else $error("non-result beat stalled");

  // a result appears only after a closing installed beat advanced
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv && s1_emit))
    else $error("result without closing installed beat");
`endif

endmodule

`default_nettype wire

/* src/vtc_parser.sv */
// ----------------------------------------------------------------------------
// vtc_parser: dotted version parser, one character per cycle while stepped
// Holds the working triple and parse phase; gives the finished triple of the
// string that ends with the current character.
// ----------------------------------------------------------------------------
`default_nettype none

module vtc_parser #(
  parameter int unsigned NUM_COMPONENTS = vtc_pkg::NumCompDefault
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire vtc_pkg::parse_ctl_t                          ctl_i,
  output logic [NUM_COMPONENTS-1:0][vtc_pkg::CompW-1:0]     fin_triple_o
);
  import vtc_pkg::*;

  localparam int unsigned SlotW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(NUM_COMPONENTS - 1);

  phase_e                                phase_q, phase_d;
  logic [SlotW-1:0]                      slot_q, slot_d;
  logic                                  ovf_q, ovf_d;
  logic [NUM_COMPONENTS-1:0][CompW-1:0]  work_q, work_d;

  logic             is_digit;
  logic [3:0]       digit;
  logic [CompW-1:0] cur;
  logic [CompW-1:0] cur_next;

  assign is_digit = (ctl_i.beat.ch >= ChZero) && (ctl_i.beat.ch <= ChNine);
  assign digit    = 4'(ctl_i.beat.ch - ChZero);

  always_comb begin
    cur = '0;
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      if (slot_q == SlotW'(i)) begin
        cur = work_q[i];
      end
    end
  end

  // times ten plus the new digit; stays below 2^30 since cur <= CompLimit here
  assign cur_next = (cur << 3) + (cur << 1) + CompW'(digit);

  always_comb begin
    phase_d = phase_q;
    slot_d  = slot_q;
    ovf_d   = ovf_q;
    work_d  = work_q;
    unique case (phase_q)
      PhSeek: begin
        if (is_digit) begin
          work_d[0] = CompW'(digit);
          slot_d    = '0;
          phase_d   = PhComp;
        end
      end
      PhComp: begin
        if (is_digit) begin
          if (cur > CompLimit) begin
            ovf_d   = 1'b1;
            phase_d = PhDone;
          end else begin
            for (int i = 0; i < NUM_COMPONENTS; i++) begin
              if (slot_q == SlotW'(i)) begin
                work_d[i] = cur_next;
              end
            end
          end
        end else if ((ctl_i.beat.ch == ChDot) && (slot_q != LastSlot)) begin
          slot_d = slot_q + SlotW'(1);
          for (int i = 1; i < NUM_COMPONENTS; i++) begin
            if (slot_q == SlotW'(i - 1)) begin
              work_d[i] = '0;
            end
          end
        end else begin
          phase_d = PhDone;
        end
      end
      PhDone: begin
      end
      default: begin
        phase_d = PhDone;
      end
    endcase
  end

  // an overflow anywhere zeroes the whole triple
  assign fin_triple_o = ovf_d ? '0 : work_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSeek;
      slot_q  <= '0;
      ovf_q   <= 1'b0;
      work_q  <= '0;
    end else if (ctl_i.step) begin
      if (ctl_i.beat.last) begin
        phase_q <= PhSeek;
        slot_q  <= '0;
        ovf_q   <= 1'b0;
        work_q  <= '0;
      end else begin
        phase_q <= phase_d;
        slot_q  <= slot_d;
        ovf_q   <= ovf_d;
        work_q  <= work_d;
      end
    end
  end

endmodule

`default_nettype wire

/* src/vtc_compare.sv */
// ----------------------------------------------------------------------------
// vtc_compare: lexicographic greater-than of two version triples
// Major component first; the first unequal component decides.
// ----------------------------------------------------------------------------
`default_nettype none

module vtc_compare #(
  parameter int unsigned NUM_COMPONENTS = vtc_pkg::NumCompDefault
) (
  input  wire logic [NUM_COMPONENTS-1:0][vtc_pkg::CompW-1:0] cand_i,
  input  wire logic [NUM_COMPONENTS-1:0][vtc_pkg::CompW-1:0] inst_i,
  output logic                                               greater_o
);
  import vtc_pkg::*;

  logic decided;

  always_comb begin
    greater_o = 1'b0;
    decided   = 1'b0;
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      if (!decided) begin
        if (cand_i[i] > inst_i[i]) begin
          greater_o = 1'b1;
          decided   = 1'b1;
        end else if (cand_i[i] < inst_i[i]) begin
          decided = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sim/vtc_checker.sv */
// ----------------------------------------------------------------------------
// vtc_checker: scoreboard for the version triple comparator
// Watches both channels. Every accepted character beat runs through a local
// parser that mirrors the block; a closing installed beat queues the
// expected result. Every accepted result beat is checked against the oldest
// queued one.
// ----------------------------------------------------------------------------
`default_nettype none

module vtc_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire vtc_pkg::in_beat_t  in_beat_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire vtc_pkg::out_beat_t out_beat_i,
  output int unsigned             err_cnt_o,
  output int unsigned             pending_o
);

  localparam int unsigned NComp      = vtc_pkg::NumCompDefault;
  localparam int unsigned Radix      = 10;
  localparam int unsigned ShownLimit = 10;
  localparam logic        ModeCand   = 1'b0;

  typedef logic [vtc_pkg::CompW-1:0] comp_t;

  vtc_pkg::phase_e    phase;
  int unsigned        slot;
  bit                 overflow_seen;
  comp_t              work_triple [NComp];
  comp_t              held_cand   [NComp];
  vtc_pkg::out_beat_t verdicts_due [$];
  int unsigned        fail_cnt = 0;
  int unsigned        due_cnt  = 0;

  assign err_cnt_o = fail_cnt;
  assign pending_o = due_cnt;

  function automatic void restart_parse();
    phase         = vtc_pkg::PhSeek;
    slot          = 0;
    overflow_seen = 1'b0;
    foreach (work_triple[i]) work_triple[i] = '0;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    logic  is_digit;
    comp_t digit;
    is_digit = (c >= vtc_pkg::ChZero) && (c <= vtc_pkg::ChNine);
    digit    = is_digit ? comp_t'(c - vtc_pkg::ChZero) : '0;
    case (phase)
      vtc_pkg::PhSeek: begin
        if (is_digit) begin
          work_triple[0] = digit;
          slot           = 0;
          phase          = vtc_pkg::PhComp;
        end
      end
      vtc_pkg::PhComp: begin
        if (slot < NComp) begin
          if (is_digit) begin
            // a digit on top of an oversized component wipes the triple
            if (work_triple[slot] > vtc_pkg::CompLimit) begin
              overflow_seen = 1'b1;
              phase         = vtc_pkg::PhDone;
            end else begin
              work_triple[slot] = comp_t'(work_triple[slot] * Radix + digit);
            end
          end else if (c == vtc_pkg::ChDot && slot + 1 < NComp) begin
            slot++;
            work_triple[slot] = '0;
          end else begin
            phase = vtc_pkg::PhDone;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void take_char(input vtc_pkg::in_beat_t b);
    comp_t              fin [NComp];
    logic               cand_gt;
    logic               decided;
    vtc_pkg::out_beat_t verdict;
    parse_char(b.ch);
    if (!b.last) return;
    foreach (fin[i]) fin[i] = overflow_seen ? '0 : work_triple[i];
    restart_parse();
    if (b.mode == ModeCand) begin
      held_cand = fin;
      return;
    end
    cand_gt = 1'b0;
    decided = 1'b0;
    for (int i = 0; i < NComp; i++) begin
      if (!decided && held_cand[i] != fin[i]) begin
        cand_gt = held_cand[i] > fin[i];
        decided = 1'b1;
      end
    end
    verdict.newer      = cand_gt;
    verdict.cand_major = held_cand[0];
    verdict.cand_minor = held_cand[1];
    verdict.cand_patch = held_cand[2];
    verdict.inst_major = fin[0];
    verdict.inst_minor = fin[1];
    verdict.inst_patch = fin[2];
    verdicts_due = {verdicts_due, verdict};
  endfunction

  function automatic void check_verdict(input vtc_pkg::out_beat_t got);
    vtc_pkg::out_beat_t want;
    if (verdicts_due.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= ShownLimit)
        $display("vtc_checker: unexpected result beat newer=%0b cand=%0d.%0d.%0d inst=%0d.%0d.%0d",
                 got.newer, got.cand_major, got.cand_minor, got.cand_patch,
                 got.inst_major, got.inst_minor, got.inst_patch);
      return;
    end
    want = verdicts_due.pop_front();
    if (got.newer !== want.newer ||
        got.cand_major !== want.cand_major || got.cand_minor !== want.cand_minor ||
        got.cand_patch !== want.cand_patch || got.inst_major !== want.inst_major ||
        got.inst_minor !== want.inst_minor || got.inst_patch !== want.inst_patch) begin
      fail_cnt++;
      if (fail_cnt <= ShownLimit) begin
        $display("vtc_checker: mismatch exp newer=%0b cand=%0d.%0d.%0d inst=%0d.%0d.%0d",
                 want.newer, want.cand_major, want.cand_minor, want.cand_patch,
                 want.inst_major, want.inst_minor, want.inst_patch);
        $display("vtc_checker:          got newer=%0b cand=%0d.%0d.%0d inst=%0d.%0d.%0d",
                 got.newer, got.cand_major, got.cand_minor, got.cand_patch,
                 got.inst_major, got.inst_minor, got.inst_patch);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      restart_parse();
      foreach (held_cand[i]) held_cand[i] = '0;
    end else begin
      if (out_valid_i && out_ready_i) check_verdict(out_beat_i);
      if (in_valid_i && in_ready_i) take_char(in_beat_i);
    end
    due_cnt = verdicts_due.size();
  end

endmodule

`default_nettype wire

/* sim/tb_version_triple_compare.sv */
// ----------------------------------------------------------------------------
// tb_version_triple_compare: testbench top for the version triple comparator
// Drives version strings into the block one character beat at a time, with
// random idle cycles on both channels, one long receiver hold-off and one
// stretch at full rate. A directed opening covers the corner cases; random
// strings follow. The checker beside the block predicts and compares; this
// top only makes stimulus, guards against a hang and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_version_triple_compare;

  localparam int unsigned RandomBeats = 1850;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned IdlePct     = 24;
  localparam logic        ModeCand    = 1'b0;
  localparam logic        ModeInst    = 1'b1;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  vtc_pkg::in_beat_t  in_beat;
  logic               out_valid;
  logic               out_ready;
  vtc_pkg::out_beat_t out_beat;

  int unsigned        err_cnt;
  int unsigned        pending;

  // stimulus control; gaps_on and hold_req are shared by sender and receiver
  bit                 gaps_on;
  bit                 hold_req;
  int unsigned        hold_left;
  int unsigned        beats_sent;
  int unsigned        idle_cycles;
  logic [7:0]         text_q [$];

  version_triple_compare dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_beat_o  (out_beat)
  );

  vtc_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_beat_i   (in_beat),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_beat_i  (out_beat),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one character beat; hold it until the block takes it. Call and
  // return at a falling edge.
  task automatic push_char(input logic mode, input logic [7:0] ch, input logic last);
    while (gaps_on && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_beat.mode <= mode;
    in_beat.ch   <= ch;
    in_beat.last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // Append one byte to the pending string.
  task automatic add_char(input logic [7:0] c);
    text_q = {text_q, c};
  endtask

  // Send the queued text as one string. A mixed string carries the other
  // mode on all but its closing beat, since only the closing beat counts.
  task automatic send_text(input logic mode, input bit mixed);
    int unsigned n;
    n = text_q.size();
    for (int unsigned k = 0; k < n; k++) begin
      if (k + 1 == n) push_char(mode, text_q[k], 1'b1);
      else            push_char(mixed ? ~mode : mode, text_q[k], 1'b0);
    end
    text_q.delete();
  endtask

  task automatic load_text(input string s);
    for (int k = 0; k < s.len(); k++) add_char(s[k]);
  endtask

  task automatic append_digits(input int unsigned n, input bit nines);
    for (int unsigned k = 0; k < n; k++)
      add_char(nines ? vtc_pkg::ChNine : 8'(vtc_pkg::ChZero + $urandom_range(9)));
  endtask

  // Build one random string: mostly well formed dotted versions with random
  // digit runs, some with prefixes, empty components or trailing junk, and
  // a few of raw noise bytes.
  task automatic build_random_text();
    int unsigned pick;
    int unsigned ncomp;
    text_q.delete();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 6)) add_char(8'($urandom));
    end else begin
      if ($urandom_range(99) < 30) begin
        repeat ($urandom_range(1, 3)) begin
          pick = $urandom_range(3);
          case (pick)
            0:       add_char("v");
            1:       add_char(" ");
            2:       add_char("=");
            default: add_char(8'($urandom));
          endcase
        end
      end
      ncomp = $urandom_range(1, 4);
      for (int unsigned k = 0; k < ncomp; k++) begin
        if (k > 0) add_char(vtc_pkg::ChDot);
        pick = $urandom_range(99);
        // leave an empty component now and then
        if (pick < 10)      ;
        else if (pick < 70) append_digits($urandom_range(1, 3), 1'b0);
        else if (pick < 84) append_digits($urandom_range(4, 8), 1'b0);
        else if (pick < 92) append_digits(9, 1'($urandom_range(1)));
        else                append_digits($urandom_range(10, 11), 1'b0);
      end
      if ($urandom_range(99) < 20) begin
        pick = $urandom_range(3);
        case (pick)
          0:       add_char("-");
          1:       add_char(vtc_pkg::ChDot);
          2:       add_char("a");
          default: add_char(8'($urandom));
        endcase
        if ($urandom_range(1)) append_digits($urandom_range(1, 2), 1'b0);
      end
    end
    if (text_q.size() == 0) add_char(8'($urandom));
  endtask

  // Receiver: random ready, one long hold-off on request, full rate while
  // gaps are off.
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
        out_ready <= 1'b0;
      end else if (gaps_on) begin
        out_ready <= ($urandom_range(99) >= IdlePct);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles without any beat on either channel.
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("tb_version_triple_compare: errors");
      $finish;
    end
  end

  initial begin
    int unsigned directed_beats;
    int unsigned rand_beats;
    bit          hold_armed;
    bit          want_cand;
    logic        cur_mode;

    in_valid   = 1'b0;
    in_beat    = '0;
    rst_n      = 1'b0;
    gaps_on    = 1'b1;
    hold_req   = 1'b0;
    beats_sent = 0;
    hold_armed = 1'b0;
    want_cand  = 1'b1;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // installed string straight after reset compares against zeros
    load_text("7");
    send_text(ModeInst, 1'b0);
    // candidate with no digits at all, extreme byte values
    add_char(8'h00);
    add_char(8'hFF);
    send_text(ModeCand, 1'b0);
    // a second candidate replaces the first; parsing stops at the letter
    load_text("2.5x9");
    send_text(ModeCand, 1'b0);
    // empty middle component, opening beats carry the candidate mode
    load_text("1..2");
    send_text(ModeInst, 1'b1);
    // overflowing component zeroes the installed triple
    load_text("1000000000");
    send_text(ModeInst, 1'b0);
    // dot right before the end; the held candidate survives a compare
    load_text("3.");
    send_text(ModeInst, 1'b0);
    directed_beats = beats_sent;

    while (beats_sent < directed_beats + RandomBeats) begin
      rand_beats = beats_sent - directed_beats;
      // run at full rate on both sides for one stretch
      gaps_on = !(rand_beats >= 1300 && rand_beats < 1600);
      // stall the receiver once while strings keep coming
      if (!hold_armed && rand_beats >= 700) begin
        hold_armed = 1'b1;
        hold_req   = 1'b1;
      end
      build_random_text();
      cur_mode = want_cand ? ModeCand : ModeInst;
      if ($urandom_range(99) < 15) cur_mode = 1'($urandom_range(1));
      send_text(cur_mode, $urandom_range(99) < 15);
      want_cand = (cur_mode == ModeInst);
    end
    in_valid <= 1'b0;

    // drain: wait for every queued result, then a few more cycles
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (err_cnt == 0) begin
      $display("tb_version_triple_compare: clean");
    end else begin
      $display("tb_version_triple_compare: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
